// File: hdl/assert_macros.svh
// assertion macros used by the sender window rtl
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/gbn_pkg.sv
// types, codes and constants of the go-back-n sender window
// no dependencies
package gbn_pkg;

  localparam int SEQ_SPACE = 8;
  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int HANDLE_W = 16;
  localparam int ACK_W = 8;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [2:0] KIND_TRANSMIT = 3'd0;
  localparam logic [2:0] KIND_RETRANSMIT = 3'd1;
  localparam logic [2:0] KIND_REFUSED = 3'd2;
  localparam logic [2:0] KIND_ACK_TAKEN = 3'd3;
  localparam logic [2:0] KIND_ACK_REJECTED = 3'd4;
  localparam logic [2:0] KIND_NONE_OUT = 3'd5;

  localparam logic [SEQ_W-1:0] MAX_WIN = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [2:0] LIMIT_RESET = 3'd7;
  localparam logic CFG_IDX_LIMIT = 1'b0;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [SEQ_W-1:0] res;
    logic             borrow;
  } alu_res_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] packet_handle;
    logic [ACK_W-1:0]    ack_num;
    logic                checksum_ok;
  } in_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SEQ_W-1:0]    seqn;
    logic [HANDLE_W-1:0] handle_out;
    logic [SEQ_W-1:0]    outstanding;
    logic                window_full;
    logic                last;
  } out_t;

endpackage

// File: hdl/gbn_alu.sv
// shared sequence-number adder / subtractor with borrow
// depends on gbn_pkg
module gbn_alu (
  input  gbn_pkg::alu_op_t            op,
  input  logic [gbn_pkg::SEQ_W-1:0]   a,
  input  logic [gbn_pkg::SEQ_W-1:0]   b,
  output gbn_pkg::alu_res_t           y
);

  logic [gbn_pkg::SEQ_W:0] b_ext;
  logic [gbn_pkg::SEQ_W:0] sum;

  always_comb begin
    unique case (op)
      gbn_pkg::ALU_ADD: b_ext = {1'b0, b};
      gbn_pkg::ALU_SUB: b_ext = ~{1'b0, b} + 1'b1;
      default:          b_ext = {1'b0, b};
    endcase
    sum = {1'b0, a} + b_ext;
    y.res = sum[gbn_pkg::SEQ_W-1:0];
    y.borrow = (op == gbn_pkg::ALU_SUB) ? sum[gbn_pkg::SEQ_W] : 1'b0;
  end

endmodule

// File: hdl/gobackn_sender_window.sv
// top level of the go-back-n sender window: sequencer, window store, config port
// depends on gbn_pkg, gbn_alu and assert_macros.svh
//
// usage:
//   a command is taken when start is high and busy is low; in_data carries
//   opcode, packet handle, ack number and checksum flag. opcode 3 is taken
//   and dropped with no result.
//   results appear on out_data for one cycle each, marked by out_strobe;
//   the receiver cannot stall, so every strobe is a finished transaction.
//   order: a send or an empty timeout goes from EXEC to REPORT, which
//   registers the result; an ack goes from EXEC through ACK2, if valid, to
//   REPORT; a timeout with n entries gives n retransmits, each via RADDR and ROUT.
//   busy is low again in the cycle of the final result, so the next command
//   may be taken while that result is shown.
//   no new command is taken before the final result; the pace is set by the
//   3-bit shared adder, used once per sequencer step, and by the registered
//   read port of the window store.
//   window_limit is written at addresses 0 to 3 of the apb-style port while idle;
//   the user must keep to this, the block does not enforce it. synchronous reset (rst_n
//   low) clears the sequence state, sets last_acked and the limit to 7, not the window store.
`include "assert_macros.svh"

module gobackn_sender_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  gbn_pkg::in_t                in_data,
  output logic                        out_strobe,
  output gbn_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbn_pkg::CFG_AW-1:0]  paddr,
  input  logic [gbn_pkg::CFG_DW-1:0]  pwdata,
  output logic [gbn_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACK2,
    ST_REPORT,
    ST_RADDR,
    ST_ROUT
  } state_t;

  localparam int SW = gbn_pkg::SEQ_W;

  state_t state_r, state_nxt;
  gbn_pkg::in_t cmd_r, cmd_nxt;
  logic [SW-1:0] next_seqn_r, next_seqn_nxt;
  logic [SW-1:0] last_acked_r, last_acked_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic [2:0] limit_r, limit_nxt;
  logic [SW-1:0] dist_r, dist_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [SW-1:0] seqn_r, seqn_nxt;
  logic [gbn_pkg::HANDLE_W-1:0] hdl_r, hdl_nxt;
  logic out_strobe_r, out_strobe_nxt;
  gbn_pkg::out_t out_r, out_nxt;

  logic [gbn_pkg::HANDLE_W-1:0] mem [gbn_pkg::SEQ_SPACE];
  logic [gbn_pkg::HANDLE_W-1:0] rd_data_r;
  logic mem_we;

  gbn_pkg::alu_op_t alu_op;
  logic [SW-1:0] alu_a, alu_b;
  gbn_pkg::alu_res_t alu_y;

  logic [SW-1:0] eff_limit;
  logic cfg_wr;
  logic ack_bad;
  logic retx_last;

  gbn_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign eff_limit = (limit_r > gbn_pkg::MAX_WIN) ? gbn_pkg::MAX_WIN : limit_r;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == gbn_pkg::CFG_IDX_LIMIT) ?
                  {{(gbn_pkg::CFG_DW-3){1'b0}}, limit_r} : '0;
  assign busy = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data = out_r;
  assign ack_bad = !cmd_r.checksum_ok || (cmd_r.ack_num[gbn_pkg::ACK_W-1:SW] != '0);
  assign retx_last = (idx_r == count_r);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    next_seqn_nxt = next_seqn_r;
    last_acked_nxt = last_acked_r;
    count_nxt = count_r;
    limit_nxt = limit_r;
    dist_nxt = dist_r;
    idx_nxt = idx_r;
    kind_nxt = kind_r;
    seqn_nxt = seqn_r;
    hdl_nxt = hdl_r;
    out_strobe_nxt = 1'b0;
    out_nxt = out_r;
    mem_we = 1'b0;
    alu_op = gbn_pkg::ALU_SUB;
    alu_a = count_r;
    alu_b = eff_limit;

    if (cfg_wr && (paddr[2] == gbn_pkg::CFG_IDX_LIMIT)) begin
      limit_nxt = pwdata[2:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_data;
          if (in_data.opcode == gbn_pkg::OP_SEND || in_data.opcode == gbn_pkg::OP_ACK ||
              in_data.opcode == gbn_pkg::OP_TIMEOUT) begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        kind_nxt = gbn_pkg::KIND_ACK_REJECTED;
        seqn_nxt = '0;
        hdl_nxt = '0;
        state_nxt = ST_REPORT;
        unique case (cmd_r.opcode)
          gbn_pkg::OP_SEND: begin
            if (alu_y.borrow) begin
              mem_we = 1'b1;
              kind_nxt = gbn_pkg::KIND_TRANSMIT;
              seqn_nxt = next_seqn_r;
              hdl_nxt = cmd_r.packet_handle;
              next_seqn_nxt = next_seqn_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              kind_nxt = gbn_pkg::KIND_REFUSED;
            end
          end
          gbn_pkg::OP_ACK: begin
            alu_a = cmd_r.ack_num[SW-1:0];
            alu_b = last_acked_r;
            if (!ack_bad) begin
              dist_nxt = alu_y.res;
              state_nxt = ST_ACK2;
            end
          end
          gbn_pkg::OP_TIMEOUT: begin
            if (count_r == '0) begin
              kind_nxt = gbn_pkg::KIND_NONE_OUT;
            end else begin
              idx_nxt = SW'(1);
              state_nxt = ST_RADDR;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ACK2: begin
        alu_a = count_r;
        alu_b = dist_r;
        state_nxt = ST_REPORT;
        if (dist_r == '0 || alu_y.borrow) begin
          kind_nxt = gbn_pkg::KIND_ACK_REJECTED;
        end else begin
          kind_nxt = gbn_pkg::KIND_ACK_TAKEN;
          seqn_nxt = cmd_r.ack_num[SW-1:0];
          count_nxt = alu_y.res;
          last_acked_nxt = cmd_r.ack_num[SW-1:0];
        end
      end
      ST_REPORT: begin
        out_strobe_nxt = 1'b1;
        out_nxt.kind = kind_r;
        out_nxt.seqn = seqn_r;
        out_nxt.handle_out = hdl_r;
        out_nxt.outstanding = count_r;
        out_nxt.window_full = !alu_y.borrow;
        out_nxt.last = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RADDR: begin
        alu_op = gbn_pkg::ALU_ADD;
        alu_a = last_acked_r;
        alu_b = idx_r;
        seqn_nxt = alu_y.res;
        state_nxt = ST_ROUT;
      end
      ST_ROUT: begin
        out_strobe_nxt = 1'b1;
        out_nxt.kind = gbn_pkg::KIND_RETRANSMIT;
        out_nxt.seqn = seqn_r;
        out_nxt.handle_out = rd_data_r;
        out_nxt.outstanding = count_r;
        out_nxt.window_full = !alu_y.borrow;
        out_nxt.last = retx_last;
        if (retx_last) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_RADDR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      next_seqn_r <= '0;
      last_acked_r <= gbn_pkg::MAX_WIN;
      count_r <= '0;
      limit_r <= gbn_pkg::LIMIT_RESET;
      out_strobe_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      next_seqn_r <= next_seqn_nxt;
      last_acked_r <= last_acked_nxt;
      count_r <= count_nxt;
      limit_r <= limit_nxt;
      out_strobe_r <= out_strobe_nxt;
      idx_r <= idx_nxt;
    end
    cmd_r <= cmd_nxt;
    dist_r <= dist_nxt;
    kind_r <= kind_nxt;
    seqn_r <= seqn_nxt;
    hdl_r <= hdl_nxt;
    out_r <= out_nxt;
  end

  // window store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[next_seqn_r] <= cmd_r.packet_handle;
    end
    rd_data_r <= mem[alu_y.res];
  end

  `ASSERT_IMP(a_last_ends_item, out_strobe_r && out_r.last, state_r == ST_IDLE)
  `ASSERT_IMP(a_mid_burst_busy, out_strobe_r && !out_r.last, busy)
  `ASSERT_IMP(a_retx_index_range, state_r == ST_ROUT, idx_r != '0 && idx_r <= count_r)
  `ASSERT_NXT(a_send_grows_window, mem_we, count_r == $past(count_r) + 1'b1)

endmodule
